FILE: rtl/core/mchc_pkg.sv
// types, constants and helpers shared by the coincidence hour counter
package mchc_pkg;

  localparam int unsigned NUM_HOURS    = 24;
  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned TIME_W       = 47;
  localparam int unsigned HOUR_W       = 5;
  localparam int unsigned CHAN_W       = 2;
  localparam int unsigned PWIDTH_W     = 16;
  localparam int unsigned WINDOW_W     = 20;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 20'd200;
  localparam logic [PWIDTH_W-1:0] WIDTH_CUT_RESET = 16'd0;

  localparam logic [63:0]       NS_PER_HOUR = 64'd3600000000000;
  localparam logic [TIME_W-1:0] DAY_NS      = TIME_W'(64'(NUM_HOURS) * NS_PER_HOUR);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

  // register index as decoded from paddr[2]
  localparam logic REG_WIDTH_CUT = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  typedef struct packed {
    logic                action;
    logic [CHAN_W-1:0]   channel;
    logic [TIME_W-1:0]   time_ns;
    logic [PWIDTH_W-1:0] pulse_width;
    logic [HOUR_W-1:0]   hour_select;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic               coincidence;
    logic [HOUR_W-1:0]  hour_bin;
    logic [COUNT_W-1:0] hour_count;
  } out_t;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_REJECT,
    KIND_PULSE
  } kind_e;

  // classified item handed from front to back
  typedef struct packed {
    kind_e              kind;
    logic [CHAN_W-1:0]  channel;
    logic [TIME_W-1:0]  time_ns;
    logic [HOUR_W-1:0]  hour_bin;
    logic               after_window;
    logic [TIME_W-1:0]  time_less_win;
  } item_t;

  function automatic logic [TIME_W-1:0] hour_edge(input int unsigned k);
    logic [63:0] prod;
    prod = 64'(k) * NS_PER_HOUR;
    return prod[TIME_W-1:0];
  endfunction

endpackage

FILE: rtl/core/mchc_front.sv
// front end: configuration registers and pulse classification
module mchc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mchc_pkg::ADDR_W-1:0]    paddr,
  input  logic [mchc_pkg::DATA_W-1:0]    pwdata,
  output logic [mchc_pkg::DATA_W-1:0]    prdata,
  input  mchc_pkg::in_t                  in_data_i,
  output mchc_pkg::item_t                item_o
);

  logic [mchc_pkg::PWIDTH_W-1:0] width_cut_q, width_cut_d;
  logic [mchc_pkg::WINDOW_W-1:0] window_q, window_d;
  logic                          wr_en;
  logic [mchc_pkg::TIME_W-1:0]   win_ext;
  logic [mchc_pkg::HOUR_W-1:0]   bin;
  logic                          pulse_ok;

  assign wr_en = psel & penable & pwrite;

  always_comb begin
    width_cut_d = width_cut_q;
    window_d    = window_q;
    if (wr_en) begin
      case (paddr[2])
        mchc_pkg::REG_WIDTH_CUT: width_cut_d = pwdata[mchc_pkg::PWIDTH_W-1:0];
        mchc_pkg::REG_WINDOW:    window_d    = pwdata[mchc_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mchc_pkg::REG_WIDTH_CUT: prdata = mchc_pkg::DATA_W'(width_cut_q);
      mchc_pkg::REG_WINDOW:    prdata = mchc_pkg::DATA_W'(window_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cut_q <= mchc_pkg::WIDTH_CUT_RESET;
      window_q    <= mchc_pkg::WINDOW_RESET;
    end else begin
      width_cut_q <= width_cut_d;
      window_q    <= window_d;
    end
  end

  assign win_ext  = mchc_pkg::TIME_W'(window_q);
  assign pulse_ok = (in_data_i.pulse_width > width_cut_q) &&
                    (in_data_i.time_ns <= mchc_pkg::DAY_NS);

  // inclusive hour ranges: an exact boundary stays in the earlier bin
  always_comb begin
    bin = '0;
    for (int unsigned k = 1; k < mchc_pkg::NUM_HOURS; k++) begin
      if (in_data_i.time_ns > mchc_pkg::hour_edge(k)) begin
        bin = mchc_pkg::HOUR_W'(k);
      end
    end
  end

  always_comb begin
    item_o.channel       = in_data_i.channel;
    item_o.time_ns       = in_data_i.time_ns;
    item_o.after_window  = in_data_i.time_ns > win_ext;
    item_o.time_less_win = in_data_i.time_ns - win_ext;
    if (in_data_i.action) begin
      item_o.kind     = mchc_pkg::KIND_READ;
      item_o.hour_bin = in_data_i.hour_select;
    end else if (pulse_ok) begin
      item_o.kind     = mchc_pkg::KIND_PULSE;
      item_o.hour_bin = bin;
    end else begin
      item_o.kind     = mchc_pkg::KIND_REJECT;
      item_o.hour_bin = '0;
    end
  end

endmodule

FILE: rtl/core/mchc_queue.sv
// short queue of classified items between front and back
module mchc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mchc_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mchc_pkg::item_t pop_item_o
);

  localparam int unsigned PTR_W = $clog2(mchc_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(mchc_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(mchc_pkg::QUEUE_DEPTH - 1);

  mchc_pkg::item_t  mem_q [mchc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = cnt_q == CNT_W'(mchc_pkg::QUEUE_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/core/mchc_back.sv
// back end: group tracking, hour counters and result register
module mchc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  mchc_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mchc_pkg::out_t  out_data_o
);

  logic [mchc_pkg::COUNT_W-1:0] counts_q [mchc_pkg::NUM_HOURS];
  logic [mchc_pkg::TIME_W-1:0]  chan_time_q [mchc_pkg::NUM_CHANNELS];
  logic [mchc_pkg::NUM_CHANNELS-1:0] seen_q, seen_d;
  logic [mchc_pkg::TIME_W-1:0]  grp_time_q;
  logic [mchc_pkg::TIME_W-1:0]  grp_thr_q;
  logic                         grp_all_recent_q;
  logic                         grp_open_q;
  logic                         out_valid_q, out_valid_d;
  mchc_pkg::out_t               out_data_q, out_data_d;

  logic [mchc_pkg::NUM_CHANNELS-1:0] recent;
  logic                         is_pulse, close_grp, coinc, in_range;
  logic [mchc_pkg::COUNT_W-1:0] cur_cnt, new_cnt;

  assign pop_o    = ~empty_i & (~out_valid_q | ~out_stall_i);
  assign is_pulse = item_i.kind == mchc_pkg::KIND_PULSE;
  assign in_range = item_i.hour_bin < mchc_pkg::HOUR_W'(mchc_pkg::NUM_HOURS);

  always_comb begin
    for (int unsigned c = 0; c < mchc_pkg::NUM_CHANNELS; c++) begin
      recent[c] = seen_q[c] & (grp_all_recent_q | (chan_time_q[c] >= grp_thr_q));
    end
  end

  // gap beyond the window closes the pending group
  assign close_grp = is_pulse & grp_open_q & item_i.after_window &
                     (item_i.time_less_win > grp_time_q);
  assign coinc     = close_grp & (recent[0] | recent[1]) & (recent[2] | recent[3]);
  assign cur_cnt   = in_range ? counts_q[item_i.hour_bin] : '0;
  assign new_cnt   = (coinc && cur_cnt != mchc_pkg::COUNT_MAX) ? cur_cnt + 1'b1 : cur_cnt;

  always_comb begin
    seen_d = seen_q;
    if (close_grp) begin
      seen_d = '0;
    end
    seen_d[item_i.channel] = 1'b1;
  end

  always_comb begin
    out_data_d = '0;
    case (item_i.kind)
      mchc_pkg::KIND_READ: begin
        out_data_d.hour_bin   = item_i.hour_bin;
        out_data_d.hour_count = cur_cnt;
      end
      mchc_pkg::KIND_PULSE: begin
        out_data_d.accepted    = 1'b1;
        out_data_d.coincidence = coinc;
        out_data_d.hour_bin    = item_i.hour_bin;
        out_data_d.hour_count  = new_cnt;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned h = 0; h < mchc_pkg::NUM_HOURS; h++) begin
        counts_q[h] <= '0;
      end
      seen_q           <= '0;
      grp_time_q       <= '0;
      grp_thr_q        <= '0;
      grp_all_recent_q <= 1'b1;
      grp_open_q       <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o && is_pulse) begin
        counts_q[item_i.hour_bin] <= new_cnt;
        seen_q           <= seen_d;
        grp_time_q       <= item_i.time_ns;
        grp_thr_q        <= item_i.time_less_win;
        grp_all_recent_q <= ~item_i.after_window;
        grp_open_q       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= out_data_d;
      if (is_pulse) begin
        chan_time_q[item_i.channel] <= item_i.time_ns;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/core/muon_coincidence_hourly_counter.sv
// top level of the muon coincidence hourly counter
// Input channel: in_valid_i/in_stall_o with one in_t per transfer; an item is
// either a detector pulse (action 0) or a read of one hour counter (action 1).
// Output channel: out_valid_o/out_stall_i with exactly one out_t per input
// item, in input order.
// Configuration: APB-style writes to width_cut (address 0) and window_ns
// (address 4); pready is always high, reads return the register value.
// Throughput: one item per cycle while the receiver does not stall. The group
// and counter update of a pulse is registered as the back end pops it from the queue.
// An item passes the two-entry queue and then the result register before
// out_valid_o rises.
// When the receiver stalls, the result register holds and the queue fills;
// in_stall_o rises once both queue entries are taken.
// Reset clears all hour counters, the channel seen flags, the open group and
// the queue, and restores width_cut to 0 and window_ns to 200.
module muon_coincidence_hourly_counter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mchc_pkg::ADDR_W-1:0] paddr,
  input  logic [mchc_pkg::DATA_W-1:0] pwdata,
  output logic [mchc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mchc_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mchc_pkg::out_t              out_data_o
);

  mchc_pkg::item_t front_item;
  mchc_pkg::item_t back_item;
  logic            q_full, q_empty, q_pop;

  assign pready     = 1'b1;
  assign in_stall_o = q_full;

  mchc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_data_i (in_data_i),
    .item_o    (front_item)
  );

  mchc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (back_item)
  );

  mchc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .item_i      (back_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/core/mchc_checker.sv
// port-level checker for the muon coincidence hourly counter
module mchc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pready,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input mchc_pkg::out_t              out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_coinc_needs_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.coincidence |-> out_data_o.accepted)
    else $error("coincidence flagged on a non-pulse result");

  a_pulse_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |->
      out_data_o.hour_bin < mchc_pkg::HOUR_W'(mchc_pkg::NUM_HOURS))
    else $error("pulse hour bin out of range");

  a_coinc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.coincidence |-> out_data_o.hour_count != '0)
    else $error("coincidence with a zero hour count");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind muon_coincidence_hourly_counter mchc_checker u_mchc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: test/mchc_hour_count_checker.sv
// action codes and the checker that predicts and compares the hourly coincidence results
`timescale 1ns / 100ps

package mchc_tb_pkg;
  localparam logic ACT_PULSE = 1'b0;
  localparam logic ACT_READ  = 1'b1;
endpackage

module mchc_hour_count_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mchc_pkg::ADDR_W-1:0] paddr,
  input  logic [mchc_pkg::DATA_W-1:0] pwdata,
  input  logic [mchc_pkg::DATA_W-1:0] prdata,
  input  logic                        pready,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  mchc_pkg::in_t               in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  mchc_pkg::out_t              out_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  logic [mchc_pkg::PWIDTH_W-1:0] width_cut_cfg;
  logic [mchc_pkg::WINDOW_W-1:0] window_cfg;
  logic [mchc_pkg::COUNT_W-1:0]  hour_count_m [mchc_pkg::NUM_HOURS];
  logic [63:0]                   chan_time_m [mchc_pkg::NUM_CHANNELS];
  logic                          chan_seen_m [mchc_pkg::NUM_CHANNELS];
  logic [63:0]                   group_time_m;
  logic                          group_open_m;

  mchc_pkg::out_t expected_q [$];
  mchc_pkg::out_t want;
  logic [63:0]    want_reg;
  int unsigned    fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (fail_count < 100)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, exp_val);
    fail_count++;
  endtask

  function automatic logic chan_in_window(input int unsigned ch);
    if (!chan_seen_m[ch])
      return 1'b0;
    if (group_time_m <= 64'(window_cfg))
      return 1'b1;
    return chan_time_m[ch] >= group_time_m - 64'(window_cfg);
  endfunction

  function automatic mchc_pkg::out_t predict_hour_result(input mchc_pkg::in_t it);
    mchc_pkg::out_t res;
    logic [63:0]    t;
    logic [63:0]    hr;
    res = '0;
    if (it.action == mchc_tb_pkg::ACT_READ) begin
      res.hour_bin = it.hour_select;
      res.hour_count = (it.hour_select < mchc_pkg::NUM_HOURS) ?
                       hour_count_m[it.hour_select] : '0;
      return res;
    end
    t = 64'(it.time_ns);
    if (it.pulse_width <= width_cut_cfg || t > 64'(mchc_pkg::DAY_NS))
      return res;
    hr = (t == 0) ? 64'd0 : (t - 64'd1) / mchc_pkg::NS_PER_HOUR;
    if (hr >= mchc_pkg::NUM_HOURS)
      hr = 64'(mchc_pkg::NUM_HOURS - 1);
    // a gap beyond the window closes the pending group
    if (group_open_m && t > group_time_m && t - group_time_m > 64'(window_cfg)) begin
      if ((chan_in_window(0) || chan_in_window(1)) &&
          (chan_in_window(2) || chan_in_window(3))) begin
        res.coincidence = 1'b1;
        if (hour_count_m[hr[mchc_pkg::HOUR_W-1:0]] != mchc_pkg::COUNT_MAX)
          hour_count_m[hr[mchc_pkg::HOUR_W-1:0]]++;
      end
      for (int i = 0; i < mchc_pkg::NUM_CHANNELS; i++)
        chan_seen_m[i] = 1'b0;
      group_open_m = 1'b0;
    end
    chan_time_m[it.channel] = t;
    chan_seen_m[it.channel] = 1'b1;
    group_time_m = t;
    group_open_m = 1'b1;
    res.accepted = 1'b1;
    res.hour_bin = hr[mchc_pkg::HOUR_W-1:0];
    res.hour_count = hour_count_m[hr[mchc_pkg::HOUR_W-1:0]];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cut_cfg = mchc_pkg::WIDTH_CUT_RESET;
      window_cfg = mchc_pkg::WINDOW_RESET;
      for (int i = 0; i < mchc_pkg::NUM_HOURS; i++)
        hour_count_m[i] = '0;
      for (int i = 0; i < mchc_pkg::NUM_CHANNELS; i++) begin
        chan_time_m[i] = '0;
        chan_seen_m[i] = 1'b0;
      end
      group_time_m = '0;
      group_open_m = 1'b0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == mchc_pkg::REG_WINDOW)
            window_cfg = pwdata[mchc_pkg::WINDOW_W-1:0];
          else
            width_cut_cfg = pwdata[mchc_pkg::PWIDTH_W-1:0];
        end else begin
          want_reg = (paddr[2] == mchc_pkg::REG_WINDOW) ? 64'(window_cfg)
                                                        : 64'(width_cut_cfg);
          if (64'(prdata) != want_reg)
            report_mismatch("register read", 64'(prdata), want_reg);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.insert(expected_q.size(), predict_hour_result(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with nothing pending", 64'(out_data_i), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.accepted != want.accepted)
            report_mismatch("accepted", 64'(out_data_i.accepted), 64'(want.accepted));
          if (out_data_i.coincidence != want.coincidence)
            report_mismatch("coincidence", 64'(out_data_i.coincidence),
                            64'(want.coincidence));
          if (out_data_i.hour_bin != want.hour_bin)
            report_mismatch("hour_bin", 64'(out_data_i.hour_bin), 64'(want.hour_bin));
          if (out_data_i.hour_count != want.hour_count)
            report_mismatch("hour_count", 64'(out_data_i.hour_count), 64'(want.hour_count));
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: test/tb_muon_coincidence_hourly_counter.sv
// testbench top: pulse and read stimulus, receiver stalls, register writes and the verdict
`timescale 1ns / 100ps

module tb_muon_coincidence_hourly_counter;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned NUM_PHASES   = 6;

  typedef enum int unsigned {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY
  } rx_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mchc_pkg::ADDR_W-1:0]   paddr;
  logic [mchc_pkg::DATA_W-1:0]   pwdata;
  logic [mchc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_stall;
  mchc_pkg::in_t                 in_data;
  logic                          out_valid;
  logic                          out_stall;
  mchc_pkg::out_t                out_data;
  int unsigned                   fail_count;
  int unsigned                   pending;
  int unsigned                   cycle_count = 0;
  logic                          hold_req;
  bit                            hold_done;

  logic [63:0]         cursor_ns;
  int unsigned         cut_now;
  int unsigned         win_now;
  int unsigned         phase_cut [NUM_PHASES] = '{0, 300, 0, 65535, 40000, 1};
  int unsigned         phase_win [NUM_PHASES] = '{200, 1000, 0, 1000000, 20'hFFFFF, 5};
  int unsigned         phase_len [NUM_PHASES] = '{150, 150, 120, 40, 150, 140};
  mchc_pkg::in_t       directed_q [$];

  muon_coincidence_hourly_counter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  mchc_hour_count_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("muon_coincidence_hourly_counter: mismatch");
      $finish;
    end
  end

  function automatic mchc_pkg::in_t pulse_item(input int unsigned ch, input logic [63:0] t,
                                               input int unsigned pw);
    mchc_pkg::in_t it;
    it = '0;
    it.action = mchc_tb_pkg::ACT_PULSE;
    it.channel = mchc_pkg::CHAN_W'(ch);
    it.time_ns = t[mchc_pkg::TIME_W-1:0];
    it.pulse_width = mchc_pkg::PWIDTH_W'(pw);
    return it;
  endfunction

  function automatic mchc_pkg::in_t read_item(input int unsigned sel);
    mchc_pkg::in_t it;
    it = '0;
    it.action = mchc_tb_pkg::ACT_READ;
    it.hour_select = mchc_pkg::HOUR_W'(sel);
    return it;
  endfunction

  task automatic add_directed(input mchc_pkg::in_t it);
    directed_q.insert(directed_q.size(), it);
  endtask

  // mostly well-formed groups on a rising time line, some noise
  function automatic mchc_pkg::in_t draw_item();
    mchc_pkg::in_t it;
    int unsigned   roll;
    int unsigned   wroll;
    int unsigned   dec;
    logic [63:0]   t;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      it = read_item(($urandom_range(0, 3) != 0) ?
                     $urandom_range(0, mchc_pkg::NUM_HOURS - 1) : $urandom_range(0, 31));
      it.channel = mchc_pkg::CHAN_W'($urandom_range(0, 3));
      it.time_ns = mchc_pkg::TIME_W'({$urandom, $urandom});
      it.pulse_width = mchc_pkg::PWIDTH_W'($urandom);
      return it;
    end
    if (roll < 65) begin
      cursor_ns += 64'($urandom_range(0, win_now));
      t = cursor_ns;
    end else if (roll < 80) begin
      cursor_ns += 64'(win_now) + 64'd1 + 64'($urandom_range(0, 2 * win_now + 500));
      t = cursor_ns;
    end else if (roll < 86) begin
      cursor_ns = (cursor_ns / mchc_pkg::NS_PER_HOUR + 64'd1) * mchc_pkg::NS_PER_HOUR;
      t = cursor_ns;
    end else if (roll < 90) begin
      dec = $urandom_range(1, 5000);
      t = (cursor_ns > 64'(dec)) ? cursor_ns - 64'(dec) : 64'd0;
    end else if (roll < 95) begin
      t = {$urandom, $urandom};
      t[63:mchc_pkg::TIME_W] = '0;
    end else begin
      cursor_ns += 64'($urandom_range(0, 32'h4000_0000)) * 64'd1000;
      t = cursor_ns;
    end
    if (cursor_ns > 64'(mchc_pkg::DAY_NS) + mchc_pkg::NS_PER_HOUR / 4)
      cursor_ns = 64'($urandom_range(0, 1000));
    wroll = $urandom_range(0, 9);
    if (cut_now >= 65535 || wroll == 0)
      it = pulse_item($urandom_range(0, 3), t, $urandom_range(0, cut_now));
    else if (wroll == 1)
      it = pulse_item($urandom_range(0, 3), t, cut_now);
    else
      it = pulse_item($urandom_range(0, 3), t, $urandom_range(cut_now + 1, 65535));
    it.hour_select = mchc_pkg::HOUR_W'($urandom_range(0, 31));
    return it;
  endfunction

  task automatic put_item(input mchc_pkg::in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left)
        burst = left;
      repeat (burst) put_item(draw_item());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic idx,
                            input logic [mchc_pkg::DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned len;
    int unsigned k;
    out_stall <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off so the queue fills and the input stalls
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        mode = rx_mode_e'($urandom_range(0, 2));
        len = $urandom_range(5, 60);
        for (k = 0; k < len; k++) begin
          case (mode)
            RX_FLOW:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            default:  out_stall <= ($urandom_range(0, 1) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    hold_req <= 1'b0;
    cursor_ns = '0;
    cut_now = 32'(mchc_pkg::WIDTH_CUT_RESET);
    win_now = 32'(mchc_pkg::WINDOW_RESET);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, mchc_pkg::REG_WIDTH_CUT, '0);
    apb_access(1'b0, mchc_pkg::REG_WINDOW, '0);

    // reset settings: width cut 0, window 200
    add_directed(read_item(0));
    add_directed(read_item(31));
    add_directed(pulse_item(0, 64'd0, 0));
    add_directed(pulse_item(0, 64'd0, 1));
    add_directed(pulse_item(2, 64'd150, 65535));
    add_directed(pulse_item(3, 64'd100, 7));
    add_directed(pulse_item(1, mchc_pkg::NS_PER_HOUR, 20));
    add_directed(pulse_item(2, mchc_pkg::NS_PER_HOUR + 64'd1, 20));
    add_directed(pulse_item(0, mchc_pkg::NS_PER_HOUR + 64'd1000, 20));
    add_directed(pulse_item(2, mchc_pkg::NS_PER_HOUR + 64'd1150, 20));
    add_directed(pulse_item(2, mchc_pkg::NS_PER_HOUR + 64'd1300, 20));
    add_directed(pulse_item(2, mchc_pkg::NS_PER_HOUR + 64'd1450, 20));
    add_directed(pulse_item(3, 2 * mchc_pkg::NS_PER_HOUR, 20));
    add_directed(pulse_item(0, 64'(mchc_pkg::DAY_NS), 5));
    add_directed(pulse_item(1, 64'(mchc_pkg::DAY_NS) + 64'd1, 5));
    add_directed(pulse_item(2, 64'h7FFF_FFFF_FFFF, 65535));
    add_directed(read_item(23));
    add_directed(read_item(24));
    add_directed(read_item(1));
    add_directed(pulse_item(2, 64'(mchc_pkg::DAY_NS), 9));
    add_directed(pulse_item(3, 64'd5, 9));
    add_directed(pulse_item(0, 64'd500, 9));
    add_directed(read_item(0));
    foreach (directed_q[i]) put_item(directed_q[i]);
    in_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      cut_now = phase_cut[p];
      win_now = phase_win[p];
      apb_access(1'b1, mchc_pkg::REG_WIDTH_CUT, mchc_pkg::DATA_W'(cut_now));
      apb_access(1'b1, mchc_pkg::REG_WINDOW, mchc_pkg::DATA_W'(win_now));
      apb_access(1'b0, mchc_pkg::REG_WIDTH_CUT, '0);
      apb_access(1'b0, mchc_pkg::REG_WINDOW, '0);
      if (p == 1)
        hold_req <= 1'b1;
      send_random(phase_len[p]);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("muon_coincidence_hourly_counter: match");
    else
      $display("muon_coincidence_hourly_counter: mismatch");
    $finish;
  end

endmodule

FILE: muon_coincidence_hourly_counter.f
rtl/core/mchc_pkg.sv
rtl/core/mchc_front.sv
rtl/core/mchc_queue.sv
rtl/core/mchc_back.sv
rtl/core/muon_coincidence_hourly_counter.sv
rtl/core/mchc_checker.sv
test/mchc_hour_count_checker.sv
test/tb_muon_coincidence_hourly_counter.sv
